// ===== sv/handshaked_serial_byte_sender_core_assert.svh =====
// Assertion macros used by the serial byte sender core.
`ifndef HANDSHAKED_SERIAL_BYTE_SENDER_CORE_ASSERT_SVH
`define HANDSHAKED_SERIAL_BYTE_SENDER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbs_pkg.sv =====
// Shared types and constants of the serial byte sender.
package sbs_pkg;

  // Buffer geometry
  localparam int MSG_DEPTH = 16;
  localparam int IDX_W     = $clog2(MSG_DEPTH);
  localparam int POS_W     = $clog2(MSG_DEPTH + 1);
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_W     = $clog2(BITS_PER_BYTE);

  // Request commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_WAIT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_START_PAUSE  = 2'd1;
  localparam logic [1:0] REG_BIT_HOLD     = 2'd2;
  localparam logic [1:0] REG_BYTE_GAP     = 2'd3;

  // Configuration reset values
  localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] START_PAUSE_RST  = 16'd50;
  localparam logic [15:0] BIT_HOLD_RST     = 16'd10;
  localparam logic [15:0] BYTE_GAP_RST     = 16'd20;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ACT_TIMEOUT = 2'd1,
    ST_CLK_TIMEOUT = 2'd2
  } status_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_ACT = 3'd1,
    PH_WAIT_CLK = 3'd2,
    PH_START    = 3'd3,
    PH_BIT_HIGH = 3'd4,
    PH_BIT_LOW  = 3'd5,
    PH_BYTE     = 3'd6
  } phase_t;

  // Input request payload
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] buffer_index;
    logic [7:0] message_byte;
    logic       act_level;
    logic       clk_level;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic       dat_level;
    logic       dat_enable;
    logic       act_enable;
    logic       clk_level_res;
    logic       clk_enable;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Timing registers
  typedef struct packed {
    logic [15:0] wait_timeout;
    logic [15:0] start_pause;
    logic [15:0] bit_hold;
    logic [15:0] byte_gap;
  } cfg_t;

  // Buffer write request from the sequencer side
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [7:0]           data;
  } store_wr_t;

endpackage

// ===== sv/sbs_store.sv =====
// Message buffer: register file with write-through forwarding on both reads.
module sbs_store (
  input  logic                        clk,
  input  sbs_pkg::store_wr_t          wr,
  input  logic [sbs_pkg::IDX_W-1:0]   rd_addr,
  output logic [7:0]                  rd_byte,
  output logic [7:0]                  head_byte
);

  logic [7:0] mem_r [sbs_pkg::MSG_DEPTH];

  // Write port, no reset: entries are undefined until loaded
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // A load in the same tick is seen by the reads
  always_comb begin
    rd_byte   = (wr.en && wr.addr == rd_addr) ? wr.data : mem_r[rd_addr];
    head_byte = (wr.en && wr.addr == '0) ? wr.data : mem_r[0];
  end

endmodule

// ===== sv/sbs_seq.sv =====
// Pin sequencer: phase machine, counters and line drive for one tick per request.
module sbs_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  sbs_pkg::in_item_t           item,
  input  sbs_pkg::cfg_t               cfg,
  input  logic [7:0]                  rd_byte,
  input  logic [7:0]                  head_byte,
  output sbs_pkg::store_wr_t          wr,
  output logic [sbs_pkg::IDX_W-1:0]   rd_addr,
  output sbs_pkg::out_item_t          result
);

  sbs_pkg::phase_t                   phase_r, phase_nxt;
  logic [sbs_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [sbs_pkg::POS_W-1:0]         len_r, len_nxt;
  logic [sbs_pkg::BIT_W-1:0]         bit_r, bit_nxt;
  logic [15:0]                       wc_r, wc_nxt;
  sbs_pkg::status_t                  status_r, status_nxt;
  logic                              done;
  logic [15:0]                       wc_inc;
  logic [sbs_pkg::POS_W-1:0]         pos_inc;
  logic                              pos_in_range;
  logic                              cur_bit;

  assign wc_inc  = wc_r + 16'd1;
  assign pos_inc = pos_r + sbs_pkg::POS_W'(1);

  // Buffer load, ignored past the depth
  always_comb begin
    wr.en   = step && item.command == sbs_pkg::CMD_LOAD &&
              32'(item.buffer_index) < sbs_pkg::MSG_DEPTH;
    wr.addr = sbs_pkg::IDX_W'(item.buffer_index);
    wr.data = item.message_byte;
  end

  // Next-state logic
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    bit_nxt    = bit_r;
    wc_nxt     = wc_r;
    status_nxt = status_r;
    done       = 1'b0;

    unique case (phase_r)
      sbs_pkg::PH_IDLE: begin
        if (item.command == sbs_pkg::CMD_START) begin
          len_nxt    = (32'(head_byte) > sbs_pkg::MSG_DEPTH) ?
                       sbs_pkg::POS_W'(sbs_pkg::MSG_DEPTH) : sbs_pkg::POS_W'(head_byte);
          pos_nxt    = '0;
          bit_nxt    = '0;
          wc_nxt     = '0;
          status_nxt = sbs_pkg::ST_OK;
          phase_nxt  = sbs_pkg::PH_WAIT_ACT;
        end
      end
      sbs_pkg::PH_WAIT_ACT: begin
        if (item.act_level) begin
          wc_nxt    = '0;
          phase_nxt = sbs_pkg::PH_WAIT_CLK;
        end else begin
          wc_nxt = wc_inc;
          if (wc_inc >= cfg.wait_timeout) begin
            status_nxt = sbs_pkg::ST_ACT_TIMEOUT;
            done       = 1'b1;
          end
        end
      end
      sbs_pkg::PH_WAIT_CLK: begin
        if (!item.clk_level) begin
          wc_nxt    = '0;
          phase_nxt = sbs_pkg::PH_START;
        end else begin
          wc_nxt = wc_inc;
          if (wc_inc >= cfg.wait_timeout) begin
            status_nxt = sbs_pkg::ST_CLK_TIMEOUT;
            done       = 1'b1;
          end
        end
      end
      sbs_pkg::PH_START: begin
        if (wc_r < cfg.start_pause) begin
          wc_nxt = wc_inc;
        end else begin
          wc_nxt = '0;
          if (len_r == '0) begin
            done = 1'b1;
          end else begin
            phase_nxt = sbs_pkg::PH_BIT_HIGH;
          end
        end
      end
      sbs_pkg::PH_BIT_HIGH: begin
        if (wc_r < cfg.bit_hold) begin
          wc_nxt = wc_inc;
        end else begin
          wc_nxt    = '0;
          phase_nxt = sbs_pkg::PH_BIT_LOW;
        end
      end
      sbs_pkg::PH_BIT_LOW: begin
        if (wc_r < cfg.bit_hold) begin
          wc_nxt = wc_inc;
        end else begin
          wc_nxt = '0;
          if (bit_r != '1) begin
            bit_nxt   = bit_r + sbs_pkg::BIT_W'(1);
            phase_nxt = sbs_pkg::PH_BIT_HIGH;
          end else begin
            phase_nxt = sbs_pkg::PH_BYTE;
          end
        end
      end
      sbs_pkg::PH_BYTE: begin
        if (wc_r < cfg.byte_gap) begin
          wc_nxt = wc_inc;
        end else begin
          wc_nxt  = '0;
          pos_nxt = pos_inc;
          if (pos_inc < len_r) begin
            bit_nxt   = '0;
            phase_nxt = sbs_pkg::PH_BIT_HIGH;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = sbs_pkg::PH_IDLE;
      end
    endcase

    // Finish or abort returns the phase to idle and clears the counters
    if (done) begin
      phase_nxt = sbs_pkg::PH_IDLE;
      wc_nxt    = '0;
      pos_nxt   = '0;
      bit_nxt   = '0;
    end
  end

  // Bit on the data line comes from the updated position
  assign rd_addr      = sbs_pkg::IDX_W'(pos_nxt);
  assign pos_in_range = 32'(pos_nxt) < sbs_pkg::MSG_DEPTH;
  assign cur_bit      = pos_in_range & rd_byte[bit_nxt];

  // Line drive from the updated phase
  always_comb begin
    result          = '0;
    result.busy_res = phase_nxt != sbs_pkg::PH_IDLE;
    result.done_res = done;
    result.status   = status_nxt;
    unique case (phase_nxt)
      sbs_pkg::PH_WAIT_CLK: begin
        result.dat_enable = 1'b1;
        result.act_enable = 1'b1;
      end
      sbs_pkg::PH_START: begin
        result.dat_level  = 1'b1;
        result.dat_enable = 1'b1;
        result.act_enable = 1'b1;
      end
      sbs_pkg::PH_BIT_HIGH, sbs_pkg::PH_BYTE: begin
        result.dat_level     = cur_bit;
        result.dat_enable    = 1'b1;
        result.act_enable    = 1'b1;
        result.clk_level_res = 1'b1;
        result.clk_enable    = 1'b1;
      end
      sbs_pkg::PH_BIT_LOW: begin
        result.dat_level  = cur_bit;
        result.dat_enable = 1'b1;
        result.act_enable = 1'b1;
        result.clk_enable = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State registers advance once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sbs_pkg::PH_IDLE;
      pos_r    <= '0;
      len_r    <= '0;
      bit_r    <= '0;
      wc_r     <= '0;
      status_r <= sbs_pkg::ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      bit_r    <= bit_nxt;
      wc_r     <= wc_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== sv/handshaked_serial_byte_sender_core.sv =====
// A request waits in the input register, its result in the result register until taken.
// Throughput: one request per cycle unless stalled; sequencer state advances once per request.
// The input register refills while a finished result waits in the result register.
// Reset (rst_n low, synchronous): sequencer idle, counters and status zero, both
// registers empty, timing registers at defaults; buffer contents are not cleared.
`include "handshaked_serial_byte_sender_core_assert.svh"

// Top level: request/result registers, timing registers, sequencer and buffer.
module handshaked_serial_byte_sender_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbs_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  logic                             in_valid_r;
  sbs_pkg::in_item_t                in_data_r;
  logic                             out_valid_r;
  sbs_pkg::out_item_t               out_data_r;
  sbs_pkg::cfg_t                    cfg_r;
  logic                             advance;
  logic                             take;
  sbs_pkg::store_wr_t               wr;
  logic [sbs_pkg::IDX_W-1:0]        rd_addr;
  logic [7:0]                       rd_byte;
  logic [7:0]                       head_byte;
  sbs_pkg::out_item_t               result;
  sbs_pkg::out_item_t               offered;

  // Handshake control
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_timeout <= sbs_pkg::WAIT_TIMEOUT_RST;
      cfg_r.start_pause  <= sbs_pkg::START_PAUSE_RST;
      cfg_r.bit_hold     <= sbs_pkg::BIT_HOLD_RST;
      cfg_r.byte_gap     <= sbs_pkg::BYTE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbs_pkg::REG_WAIT_TIMEOUT: cfg_r.wait_timeout <= cfg_wdata;
        sbs_pkg::REG_START_PAUSE:  cfg_r.start_pause  <= cfg_wdata;
        sbs_pkg::REG_BIT_HOLD:     cfg_r.bit_hold     <= cfg_wdata;
        sbs_pkg::REG_BYTE_GAP:     cfg_r.byte_gap     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sbs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_data_r),
    .cfg       (cfg_r),
    .rd_byte   (rd_byte),
    .head_byte (head_byte),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .result    (result)
  );

  sbs_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_byte   (rd_byte),
    .head_byte (head_byte)
  );

  // Result fields only while a result is offered
  assign offered = out_valid_r ? out_data_r : '0;

  // A moved request always lands in the result register
  `SBS_ASSERT_NEXT(a_advance_fills, advance, out_valid_r, "request lost between registers")
  // A finishing tick is never also busy
  `SBS_ASSERT_NOW(a_done_not_busy, offered.done_res, !offered.busy_res, "done while busy")
  // Clock is only driven with data and activity driven
  `SBS_ASSERT_NOW(a_clk_drive, offered.clk_enable, offered.dat_enable && offered.act_enable, "clock driven alone")
  // A send in progress always reports a clean status
  `SBS_ASSERT_NOW(a_busy_status, offered.busy_res, offered.status == sbs_pkg::ST_OK, "busy with error")

endmodule
